[rtl/u8sd_pkg.sv]
// Shared types, constants and the lead-byte classifier for the UTF-8 stream decoder.
package u8sd_pkg;

    localparam int INDEX_BITS_DEF = 16;
    localparam int CP_BITS        = 32;
    // queue depth must be a power of two so the pointers wrap on their own
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [1:0] CONT_TAG     = 2'b10;
    localparam logic [7:0] PAYLOAD_MASK = 8'h3F;
    localparam logic [7:0] LEAD_MASK    = 8'hFF;

    // leading-ones codes with a meaning of their own
    localparam logic [3:0] ONES_SINGLE  = 4'd0;
    localparam logic [3:0] ONES_CONT    = 4'd1;
    localparam logic [3:0] ONES_ALL     = 4'd8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [3:0] ones;
        logic       is_zero;
    } u8sd_item_t;

    function automatic logic [3:0] lead_ones(input logic [7:0] b);
        logic [3:0] n;
        logic       stop;
        n    = '0;
        stop = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!stop && b[i]) begin
                n = n + 4'd1;
            end else begin
                stop = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

[rtl/utf8_stream_decoder.sv]
// UTF-8 stream decoder top level: byte requests in, code points out.
//
// Usage:
//   Input channel s_valid/s_ready/s_data_byte carries one byte of a
//   zero-terminated UTF-8 string per request. Output channel
//   m_valid/m_ready/m_code_point carries decoded code points; the zero byte
//   yields an end result with code point zero and clears the decode state.
//   cfg_wen/cfg_wdata write the capacity register (reset all ones); write it
//   only while the block is idle. Zero capacity suppresses all results.
// Timing:
//   One byte per cycle sustained while the result side does not stall. A byte
//   accepted goes through the front stage register, a queue entry and the back
//   stage result register to m_valid, and waits longer if the queue is backed up.
//   The front stage and a 4-entry queue keep taking bytes while the result
//   register is stalled; s_ready drops only once the queue is full.
// Reset:
//   aresetn is synchronous, active low; it empties the queue, drops pending
//   results and restores capacity to all ones.
module utf8_stream_decoder import u8sd_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wen,
    input  logic [INDEX_BITS-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_data_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CP_BITS-1:0]    m_code_point
);

    logic       push_valid;
    logic       push_ready;
    u8sd_item_t push_item;
    logic       q_valid;
    logic       q_pop;
    u8sd_item_t q_item;

    u8sd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data_byte(s_data_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    u8sd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_item (push_item),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_item  (q_item)
    );

    u8sd_back #(
        .INDEX_BITS(INDEX_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_code_point(m_code_point)
    );

endmodule

[rtl/u8sd_front.sv]
// Front stage: accept request bytes, classify them and hand them to the queue.
module u8sd_front import u8sd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       push_valid,
    input  logic       push_ready,
    output u8sd_item_t push_item
);

    logic       vld_reg;
    logic       vld_next;
    u8sd_item_t item_reg;
    u8sd_item_t item_next;
    logic       take;

    assign s_ready    = !vld_reg || push_ready;
    assign take       = s_valid && s_ready;
    assign push_valid = vld_reg;
    assign push_item  = item_reg;

    always_comb begin
        vld_next  = vld_reg;
        item_next = item_reg;
        if (take) begin
            vld_next            = 1'b1;
            item_next.data_byte = s_data_byte;
            item_next.ones      = lead_ones(s_data_byte);
            item_next.is_zero   = (s_data_byte == 8'd0);
        end else if (push_ready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        item_reg <= item_next;
    end

endmodule

[rtl/u8sd_queue.sv]
// Short queue of classified bytes between the front and back stages.
module u8sd_queue import u8sd_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    output logic       push_ready,
    input  u8sd_item_t push_item,
    output logic       pop_valid,
    input  logic       pop,
    output u8sd_item_t pop_item
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    u8sd_item_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (count_reg != CNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

[rtl/u8sd_back.sv]
// Back stage: sequence state, character counting and the result register.
module u8sd_back import u8sd_pkg::*; #(
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wen,
    input  logic [INDEX_BITS-1:0] cfg_wdata,
    input  logic                  q_valid,
    input  u8sd_item_t            q_item,
    output logic                  q_pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CP_BITS-1:0]    m_code_point
);

    logic [INDEX_BITS-1:0] capacity_reg;
    logic [INDEX_BITS-1:0] capacity_next;
    logic [2:0]            bytes_left_reg;
    logic [2:0]            bytes_left_next;
    logic [CP_BITS-1:0]    acc_reg;
    logic [CP_BITS-1:0]    acc_next;
    logic [INDEX_BITS-1:0] char_count_reg;
    logic [INDEX_BITS-1:0] char_count_next;
    logic                  halted_reg;
    logic                  halted_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [CP_BITS-1:0]    cp_reg;
    logic [CP_BITS-1:0]    cp_next;

    logic                  out_free;
    logic                  fin;
    logic [CP_BITS-1:0]    fin_val;
    logic                  emit;
    logic [CP_BITS-1:0]    emit_val;
    logic [CP_BITS-1:0]    acc_shift;
    logic [7:0]            lead_mask;

    assign out_free     = !m_valid_reg || m_ready;
    assign q_pop        = q_valid && out_free;
    assign m_valid      = m_valid_reg;
    assign m_code_point = cp_reg;

    always_comb begin
        capacity_next   = cfg_wen ? cfg_wdata : capacity_reg;
        bytes_left_next = bytes_left_reg;
        acc_next        = acc_reg;
        char_count_next = char_count_reg;
        halted_next     = halted_reg;
        fin             = 1'b0;
        fin_val         = '0;
        emit            = 1'b0;
        emit_val        = '0;
        acc_shift       = {acc_reg[CP_BITS-7:0], q_item.data_byte[5:0]};
        lead_mask       = LEAD_MASK >> (q_item.ones + 4'd1);

        if (q_pop) begin
            if (q_item.is_zero) begin
                // end of string: one end result unless capacity is zero, then clear everything
                emit            = (capacity_reg != '0);
                bytes_left_next = '0;
                acc_next        = '0;
                char_count_next = '0;
                halted_next     = 1'b0;
            end else if (!halted_reg) begin
                if (bytes_left_reg != '0 && q_item.data_byte[7:6] == CONT_TAG) begin
                    acc_next        = acc_shift;
                    bytes_left_next = bytes_left_reg - 3'd1;
                    if (bytes_left_reg == 3'd1) begin
                        fin     = 1'b1;
                        fin_val = acc_shift;
                    end
                end else begin
                    // drop any partial character and take the byte as a lead
                    bytes_left_next = '0;
                    acc_next        = '0;
                    priority if (q_item.ones == ONES_SINGLE) begin
                        fin     = 1'b1;
                        fin_val = {{(CP_BITS-8){1'b0}}, q_item.data_byte};
                    end else if (q_item.ones == ONES_CONT || q_item.ones == ONES_ALL) begin
                        halted_next = 1'b1;
                    end else begin
                        acc_next        = {{(CP_BITS-8){1'b0}}, q_item.data_byte & lead_mask};
                        bytes_left_next = 3'(q_item.ones - 4'd1);
                    end
                end
            end
        end

        if (fin) begin
            emit     = (char_count_reg < capacity_reg);
            emit_val = fin_val & {(CP_BITS/8){LEAD_MASK}};
            if (char_count_reg != '1) begin
                char_count_next = char_count_reg + 1'b1;
            end
        end

        if (emit) begin
            m_valid_next = 1'b1;
            cp_next      = emit_val;
        end else begin
            m_valid_next = m_valid_reg && !m_ready;
            cp_next      = cp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg   <= '1;
            bytes_left_reg <= '0;
            acc_reg        <= '0;
            char_count_reg <= '0;
            halted_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            capacity_reg   <= capacity_next;
            bytes_left_reg <= bytes_left_next;
            acc_reg        <= acc_next;
            char_count_reg <= char_count_next;
            halted_reg     <= halted_next;
            m_valid_reg    <= m_valid_next;
        end
        cp_reg <= cp_next;
    end

    a_seq_len: assert property (@(posedge aclk) disable iff (!aresetn)
        bytes_left_reg <= 3'd6)
        else $error("sequence length out of range");

    a_halt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> (bytes_left_reg == '0))
        else $error("halted inside a sequence");

    a_zero_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_item.is_zero) |=>
            (bytes_left_reg == '0 && !halted_reg && char_count_reg == '0))
        else $error("state not cleared after end byte");

    a_pop_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !q_pop)
        else $error("pop while result register is stalled");

endmodule

[verif/testbench.sv]
// Self-checking testbench for utf8_stream_decoder: random and directed byte strings.
module testbench;
    import u8sd_pkg::*;

    localparam int IDX_W         = INDEX_BITS_DEF;
    localparam int SETTLE_CYCLES = 12;
    localparam int PHASE_BYTES   = 125;

    // Predicts the code points of the byte stream and checks them in order.
    class cp_scoreboard;
        logic [IDX_W-1:0]   capacity;
        logic [2:0]         bytes_left;
        logic [CP_BITS-1:0] accumulator;
        logic [IDX_W-1:0]   char_count;
        logic               halted;
        logic [CP_BITS-1:0] expected_cps [$];
        int                 errors;
        int                 checked;
        int                 strings_ended;

        function new();
            capacity      = '1;
            errors        = 0;
            checked       = 0;
            strings_ended = 0;
            clear_string();
        endfunction

        function void clear_string();
            bytes_left  = '0;
            accumulator = '0;
            char_count  = '0;
            halted      = 1'b0;
        endfunction

        function int count_ones(logic [7:0] b);
            int n;
            n = 0;
            while (n < 8 && b[7-n]) n++;
            return n;
        endfunction

        function void complete_char(logic [CP_BITS-1:0] value);
            if (char_count < capacity) expected_cps.push_back(value);
            if (char_count != '1) char_count++;
        endfunction

        function void start_char(logic [7:0] b);
            int ones;
            ones = count_ones(b);
            if (ones == 0) begin
                complete_char({24'd0, b});
            end else if (ones == 1 || ones == 8) begin
                halted = 1'b1;
            end else begin
                accumulator = {24'd0, b & ((8'h80 >> ones) - 8'd1)};
                bytes_left  = 3'(ones - 1);
            end
        endfunction

        // Returns 0 when the byte is dropped by a halted decoder.
        function bit note_byte(logic [7:0] b);
            if (b == 8'h00) begin
                if (capacity != '0) expected_cps.push_back('0);
                clear_string();
                strings_ended++;
                return 1'b1;
            end
            if (halted) return 1'b0;
            if (bytes_left != 0) begin
                if (b[7:6] == CONT_TAG) begin
                    accumulator = {accumulator[CP_BITS-7:0], b[5:0]};
                    bytes_left--;
                    if (bytes_left == 0) complete_char(accumulator);
                end else begin
                    bytes_left  = '0;
                    accumulator = '0;
                    start_char(b);
                end
            end else begin
                start_char(b);
            end
            return 1'b1;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_code_point(logic [CP_BITS-1:0] cp);
            logic [CP_BITS-1:0] want;
            if (expected_cps.size() == 0) begin
                report($sformatf("unexpected code point %h", cp));
            end else begin
                want = expected_cps.pop_front();
                checked++;
                if (cp !== want) report($sformatf("code point %h, expected %h", cp, want));
            end
        endtask
    endclass

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wen     = 1'b0;
    logic [IDX_W-1:0]   cfg_wdata   = '0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [7:0]         s_data_byte = '0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic [CP_BITS-1:0] m_code_point;

    cp_scoreboard sb;
    bit           no_idle     = 1'b0;
    int           stall_left  = 0;
    int           bytes_sent  = 0;
    int           bytes_taken = 0;

    logic [7:0] intro_seq [$] = '{
        8'h41, 8'h7F, 8'h01,
        8'hC3, 8'hA9,
        8'hE2, 8'h82, 8'hAC,
        8'hF0, 8'h9F, 8'h98, 8'h80,
        8'hE2, 8'h41,
        8'hFE, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF,
        8'h80, 8'hC3, 8'h00,
        8'hFF, 8'h41, 8'h00,
        8'hE2, 8'h82, 8'h00
    };

    utf8_stream_decoder uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_point (m_code_point)
    );

    always #5 aclk = ~aclk;

    // Result side back-pressure: mostly short stalls, a few long ones.
    always @(posedge aclk) begin
        if (no_idle) begin
            m_ready    <= 1'b1;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (m_ready && $urandom_range(0, 99) < 25) begin
            m_ready    <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                      : $urandom_range(0, 3);
        end else begin
            m_ready    <= 1'b1;
            stall_left <= $urandom_range(0, 8);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_code_point(m_code_point);
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    task send_byte(logic [7:0] b, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        if (sb.note_byte(b)) bytes_taken++;
    endtask

    // Hold the sender until every predicted result is out, then let the pipe settle.
    task drain();
        s_valid <= 1'b0;
        while (sb.expected_cps.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task write_capacity(logic [IDX_W-1:0] value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wen     <= 1'b0;
        sb.capacity  = value;
    endtask

    task send_random_unit();
        int         r;
        int         len;
        int         k;
        logic [7:0] lead;
        r    = $urandom_range(0, 99);
        len  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 7) : $urandom_range(2, 4);
        lead = (8'hFF << (8 - len)) | (8'($urandom) & ((8'h80 >> len) - 8'd1));
        if (r < 38) begin
            send_byte(8'($urandom_range(1, 127)), pick_gap());
        end else if (r < 73) begin
            send_byte(lead, pick_gap());
            for (k = 1; k < len; k++) send_byte(8'h80 | 8'($urandom_range(0, 63)), pick_gap());
        end else if (r < 81) begin
            // cut the sequence short with a byte that is not a continuation
            send_byte(lead, pick_gap());
            for (k = $urandom_range(0, len - 2); k > 0; k--)
                send_byte(8'h80 | 8'($urandom_range(0, 63)), pick_gap());
            case ($urandom_range(0, 3))
                0: send_byte(8'($urandom_range(1, 127)), pick_gap());
                1: send_byte(8'hC0 | 8'($urandom_range(0, 31)), pick_gap());
                2: send_byte(8'h00, pick_gap());
                default: send_byte(8'hFF, pick_gap());
            endcase
        end else if (r < 86) begin
            send_byte(8'h80 | 8'($urandom_range(0, 63)), pick_gap());
            for (k = $urandom_range(0, 4); k > 0; k--)
                send_byte(8'($urandom_range(1, 255)), pick_gap());
        end else if (r < 88) begin
            send_byte(8'hFF, pick_gap());
        end else if (r < 91) begin
            send_byte(8'($urandom_range(0, 255)), pick_gap());
        end else begin
            send_byte(8'h00, pick_gap());
        end
    endtask

    initial begin
        int               phase;
        int               target;
        logic [IDX_W-1:0] cap;
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed strings at the reset capacity
        foreach (intro_seq[i]) send_byte(intro_seq[i], pick_gap());
        drain();

        // one-entry destination: second char dropped, end still given
        write_capacity(IDX_W'(1));
        send_byte(8'h41, 0);
        send_byte(8'h42, 0);
        send_byte(8'h00, 0);
        drain();

        // zero capacity: nothing comes out at all
        write_capacity('0);
        send_byte(8'h41, 0);
        send_byte(8'hC3, 1);
        send_byte(8'hA9, 0);
        send_byte(8'h00, 0);
        drain();

        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: cap = IDX_W'(3);
                1: cap = IDX_W'($urandom_range(2, 40));
                2: cap = '0;
                3: cap = '1;
                4: cap = IDX_W'(1);
                default: cap = IDX_W'($urandom_range(0, 65535));
            endcase
            write_capacity(cap);
            no_idle = (phase == 3);
            target  = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) send_random_unit();
            send_byte(8'h00, pick_gap());
            no_idle = 1'b0;
            drain();
        end

        $display("covered %0d bytes (%0d decoded), %0d code points checked, %0d strings",
                 bytes_sent, bytes_taken, sb.checked, sb.strings_ended);
        $display("capacities from zero to full, broken and halted strings, back-to-back bursts");
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/u8sd_pkg.sv
rtl/u8sd_front.sv
rtl/u8sd_queue.sv
rtl/u8sd_back.sv
rtl/utf8_stream_decoder.sv
verif/testbench.sv
